// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/sha1_pkg.sv -----
`default_nettype none
package sha1_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlockLen = 16;
    localparam int unsigned Rounds   = 80;
    localparam int unsigned HashLen  = 5;

    typedef logic [WordW-1:0] word_t;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam word_t H0_INIT = 32'h67452301;
    localparam word_t H1_INIT = 32'hEFCDAB89;
    localparam word_t H2_INIT = 32'h98BADCFE;
    localparam word_t H3_INIT = 32'h10325476;
    localparam word_t H4_INIT = 32'hC3D2E1F0;

    localparam word_t MARKER_WORD = 32'h80000000;
    localparam logic [7:0] MARKER_BYTE = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PAD   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Control of the message schedule shift line.
    typedef struct packed {
        logic shift;
        logic load;
    } sched_ctrl_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            default: v = H4_INIT;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha1_in_if.sv -----
`default_nettype none
interface sha1_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_in;

    modport source (output valid, output data_word, output valid_bytes, output last_in,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input last_in,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha1_out_if.sv -----
`default_nettype none
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha1_message_hasher_unit.sv -----
// Channel  Modport  Word carries
// msg      sink     data_word[31:0], valid_bytes[2:0], last_in
// digest   source   digest_word[31:0], word_index[2:0], last_word
//
// A message word is taken only while the sequencer is idle; the sixteenth word of a
// block starts 80 rounds in the shared round unit, one round per cycle.
// A last word is followed by the padding words, with 80 rounds for each block they
// complete, and then by the hand-off of the digest to the output buffer.
// rst_n asynchronously resets the sequencer and counters and loads the initial chaining value.
// The digest drains from its own buffer, so a stalled sink only holds the next digest.
`default_nettype none
module sha1_message_hasher_unit (
    input  wire          clk,
    input  wire          rst_n,
    sha1_in_if.sink      msg,
    sha1_out_if.source   digest
);

    sha1_pkg::state_t state_reg, state_next;

    logic [3:0]  wpos_reg, wpos_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [63:0] byte_count_reg, byte_count_next;
    logic        pad_active_reg, pad_active_next;
    logic        marker_reg, marker_next;
    logic        hi_done_reg, hi_done_next;
    logic        final_reg, final_next;

    sha1_pkg::word_t h_reg [sha1_pkg::HashLen];
    sha1_pkg::word_t h_next [sha1_pkg::HashLen];
    sha1_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t a_next, b_next, c_next, d_next, e_next;

    sha1_pkg::word_t dig_reg [sha1_pkg::HashLen];
    sha1_pkg::word_t dig_next [sha1_pkg::HashLen];
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_busy_reg, out_busy_next;

    sha1_pkg::sched_ctrl_t sched_ctrl;
    sha1_pkg::word_t push_word;
    sha1_pkg::word_t w_cur;
    sha1_pkg::word_t t_val;
    sha1_pkg::word_t padded_word;
    logic        push_en;
    logic        in_fire;
    logic        out_fire;
    logic [2:0]  nb_eff;
    logic [63:0] bit_count;

    assign msg.ready  = (state_reg == sha1_pkg::ST_IDLE);
    assign in_fire    = msg.valid && msg.ready;
    assign out_fire   = digest.valid && digest.ready;

    assign digest.valid       = out_busy_reg;
    assign digest.digest_word = dig_reg[0];
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = (out_idx_reg == 3'd4);

    assign nb_eff    = !msg.last_in ? 3'd4 : ((msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes);
    assign bit_count = {byte_count_reg[60:0], 3'b000};

    // Short last word: keep the valid bytes and put the marker byte right below them.
    always_comb
    begin
        case (nb_eff[1:0])
            2'd0:    padded_word = sha1_pkg::MARKER_WORD;
            2'd1:    padded_word = {msg.data_word[31:24], sha1_pkg::MARKER_BYTE, 16'h0000};
            2'd2:    padded_word = {msg.data_word[31:16], sha1_pkg::MARKER_BYTE, 8'h00};
            default: padded_word = {msg.data_word[31:8], sha1_pkg::MARKER_BYTE};
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        rnd_next        = rnd_reg;
        byte_count_next = byte_count_reg;
        pad_active_next = pad_active_reg;
        marker_next     = marker_reg;
        hi_done_next    = hi_done_reg;
        final_next      = final_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        for (int i = 0; i < sha1_pkg::HashLen; i++)
        begin
            h_next[i]   = h_reg[i];
        end
        push_en   = 1'b0;
        push_word = msg.data_word;
        sched_ctrl.shift = 1'b0;
        sched_ctrl.load  = 1'b0;

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    push_en         = 1'b1;
                    byte_count_next = byte_count_reg + {61'd0, nb_eff};
                    if (msg.last_in)
                    begin
                        pad_active_next = 1'b1;
                        hi_done_next    = 1'b0;
                        marker_next     = (nb_eff == 3'd4);
                        if (nb_eff != 3'd4)
                        begin
                            push_word = padded_word;
                        end
                    end
                end
            end
            sha1_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                if (marker_reg)
                begin
                    push_word   = sha1_pkg::MARKER_WORD;
                    marker_next = 1'b0;
                end
                else if (wpos_reg == 4'd14)
                begin
                    push_word    = bit_count[63:32];
                    hi_done_next = 1'b1;
                end
                else if (wpos_reg == 4'd15 && hi_done_reg)
                begin
                    push_word  = bit_count[31:0];
                    final_next = 1'b1;
                end
                else
                begin
                    push_word = '0;
                end
            end
            sha1_pkg::ST_ROUND:
            begin
                sched_ctrl.shift = 1'b1;
                a_next = t_val;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                if (rnd_reg == 7'(sha1_pkg::Rounds - 1))
                begin
                    rnd_next  = '0;
                    h_next[0] = h_reg[0] + t_val;
                    h_next[1] = h_reg[1] + a_reg;
                    h_next[2] = h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                    h_next[3] = h_reg[3] + c_reg;
                    h_next[4] = h_reg[4] + d_reg;
                    if (final_reg)
                    begin
                        state_next = sha1_pkg::ST_DONE;
                    end
                    else if (pad_active_reg)
                    begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha1_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            sha1_pkg::ST_DONE:
            begin
                if (!out_busy_reg)
                begin
                    for (int i = 0; i < sha1_pkg::HashLen; i++)
                    begin
                        h_next[i] = sha1_pkg::init_hash(3'(i));
                    end
                    byte_count_next = '0;
                    pad_active_next = 1'b0;
                    final_next      = 1'b0;
                    hi_done_next    = 1'b0;
                    marker_next     = 1'b0;
                    state_next      = sha1_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase

        // A word pushed into the last slot of the block starts a compression.
        if (push_en)
        begin
            sched_ctrl.shift = 1'b1;
            sched_ctrl.load  = 1'b1;
            wpos_next        = wpos_reg + 4'd1;
            if (wpos_reg == 4'd15)
            begin
                state_next = sha1_pkg::ST_ROUND;
                a_next = h_reg[0];
                b_next = h_reg[1];
                c_next = h_reg[2];
                d_next = h_reg[3];
                e_next = h_reg[4];
            end
            else if (state_reg == sha1_pkg::ST_IDLE && msg.last_in)
            begin
                state_next = sha1_pkg::ST_PAD;
            end
        end
    end

    // Output buffer: a five-word shift line drained one word per handshake.
    always_comb
    begin
        out_busy_next = out_busy_reg;
        out_idx_next  = out_idx_reg;
        for (int i = 0; i < sha1_pkg::HashLen; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        if (state_reg == sha1_pkg::ST_DONE && !out_busy_reg)
        begin
            out_busy_next = 1'b1;
            out_idx_next  = '0;
            for (int i = 0; i < sha1_pkg::HashLen; i++)
            begin
                dig_next[i] = h_reg[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < sha1_pkg::HashLen - 1; i++)
            begin
                dig_next[i] = dig_reg[i+1];
            end
            if (out_idx_reg == 3'd4)
            begin
                out_busy_next = 1'b0;
                out_idx_next  = '0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha1_pkg::ST_IDLE;
            wpos_reg       <= '0;
            rnd_reg        <= '0;
            byte_count_reg <= '0;
            pad_active_reg <= 1'b0;
            marker_reg     <= 1'b0;
            hi_done_reg    <= 1'b0;
            final_reg      <= 1'b0;
            out_busy_reg   <= 1'b0;
            out_idx_reg    <= '0;
            for (int i = 0; i < sha1_pkg::HashLen; i++)
            begin
                h_reg[i] <= sha1_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg      <= state_next;
            wpos_reg       <= wpos_next;
            rnd_reg        <= rnd_next;
            byte_count_reg <= byte_count_next;
            pad_active_reg <= pad_active_next;
            marker_reg     <= marker_next;
            hi_done_reg    <= hi_done_next;
            final_reg      <= final_next;
            out_busy_reg   <= out_busy_next;
            out_idx_reg    <= out_idx_next;
            for (int i = 0; i < sha1_pkg::HashLen; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        for (int i = 0; i < sha1_pkg::HashLen; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
    end

    sha1_schedule u_schedule (
        .clk       (clk),
        .ctrl      (sched_ctrl),
        .load_word (push_word),
        .w_cur     (w_cur)
    );

    sha1_round u_round (
        .rnd (rnd_reg),
        .a   (a_reg),
        .b   (b_reg),
        .c   (c_reg),
        .d   (d_reg),
        .e   (e_reg),
        .w   (w_cur),
        .t   (t_val)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/sha1_schedule.sv -----
`default_nettype none
module sha1_schedule (
    input  wire                  clk,
    input  sha1_pkg::sched_ctrl_t ctrl,
    input  sha1_pkg::word_t      load_word,
    output sha1_pkg::word_t      w_cur
);

    sha1_pkg::word_t w_reg  [sha1_pkg::BlockLen];
    sha1_pkg::word_t w_next [sha1_pkg::BlockLen];
    sha1_pkg::word_t expand_x;
    sha1_pkg::word_t expand_w;

    // The window holds W[t] .. W[t+15]; the word shifted in during round t is W[t+16].
    assign expand_x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign expand_w = {expand_x[30:0], expand_x[31]};
    assign w_cur    = w_reg[0];

    always_comb
    begin
        for (int i = 0; i < sha1_pkg::BlockLen - 1; i++)
        begin
            w_next[i] = w_reg[i+1];
        end
        w_next[sha1_pkg::BlockLen-1] = ctrl.load ? load_word : expand_w;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < sha1_pkg::BlockLen; i++)
            begin
                w_reg[i] <= w_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sha1_round.sv -----
`default_nettype none
module sha1_round (
    input  wire  [6:0]           rnd,
    input  sha1_pkg::word_t      a,
    input  sha1_pkg::word_t      b,
    input  sha1_pkg::word_t      c,
    input  sha1_pkg::word_t      d,
    input  sha1_pkg::word_t      e,
    input  sha1_pkg::word_t      w,
    output sha1_pkg::word_t      t
);

    sha1_pkg::word_t f;
    sha1_pkg::word_t k;

    always_comb
    begin
        if (rnd < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K0;
        end
        else if (rnd < 7'd40)
        begin
            f = b ^ c ^ d;
            k = sha1_pkg::K1;
        end
        else if (rnd < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = sha1_pkg::K3;
        end
    end

    assign t = {a[26:0], a[31:27]} + f + e + k + w;

endmodule
`default_nettype wire

// ----- hw/rtl/sha1_hasher_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module sha1_hasher_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        in_last,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] out_digest,
    input wire [2:0]  out_index,
    input wire        out_last
);

    // A stalled digest word holds its value.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digest))

    // The final flag marks exactly the fifth digest word.
    `ASSERT_SAME(a_last_index, out_valid, out_last == (out_index == 3'd4))

    // Digest words come out in order without gaps.
    `ASSERT_NEXT(a_index_step, out_valid && out_ready && !out_last,
                 out_valid && out_index == $past(out_index) + 3'd1)

    // The last word of a message always starts padding, so input stalls next.
    `ASSERT_NEXT(a_pad_stall, in_valid && in_ready && in_last, !in_ready)

endmodule

bind sha1_message_hasher_unit sha1_hasher_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (msg.valid),
    .in_ready   (msg.ready),
    .in_last    (msg.last_in),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .out_digest (digest.digest_word),
    .out_index  (digest.word_index),
    .out_last   (digest.last_word)
);
`default_nettype wire
